// File: rtl/sutp_pkg.sv
// ----------------------------------------------------------------------------
// sutp_pkg
// Shared types and constants for the bit-timed UART with parity.
// ----------------------------------------------------------------------------
`default_nettype none

package sutp_pkg;

  localparam int RX_DEPTH = 128;
  localparam int TX_DEPTH = 128;

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  localparam logic [3:0] SLOT_START  = 4'd0;
  localparam logic [3:0] SLOT_LAST_D = 4'd8;
  localparam logic [3:0] SLOT_PARITY = 4'd9;
  localparam logic [3:0] SLOT_STOP   = 4'd10;

  localparam logic [2:0] PARITY_RESET = 3'd3;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_ARM   = 3'd3,
    CMD_POP   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    PAR_NONE  = 3'd0,
    PAR_MARK  = 3'd1,
    PAR_SPACE = 3'd2,
    PAR_EVEN  = 3'd3,
    PAR_ODD   = 3'd4
  } par_t;

  typedef struct packed {
    logic [1:0] pad;
    logic       rx_overflow;
    logic       byte_received;
    logic       parity_error;
    logic [7:0] rx_fill;
    logic       rx_data_valid;
    logic [7:0] rx_data;
    logic       tx_busy;
    logic       tx_line;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/sutp_ram.sv
// ----------------------------------------------------------------------------
// sutp_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// A read of the address written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module sutp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/soft_uart_parity_txrx_top.sv
// ----------------------------------------------------------------------------
// soft_uart_parity_txrx_top
// Bit-timed UART transmitter and receiver with selectable parity.
// ----------------------------------------------------------------------------
// Every command arrives as one transfer on the slave stream: tuser carries the
// command, tdata the receive pin sample and the write or send arguments. Each
// command gives exactly one status transfer on the master stream. While the
// master side takes results, a command can be taken in every cycle, so
// throughput is one item per cycle; the transmit buffer and the receive ring
// sit in two RAMs with a registered read at the address the next command will
// need. The parity register is written through cfg_we and cfg_wdata; the user
// must write it only while idle, as the block does not check this. Reset
// clears the bit counters, ring pointers and flags; the RAM contents are left
// as they are and must be written before they are read. The output holds two
// results: when the master side stalls, one more command is taken into the
// skid register and then tready drops until a result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_uart_parity_txrx_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // rx_line[0], tx_byte[8:1], tx_index[15:9], tx_length[23:16]
  input  wire logic [23:0] s_tdata,
  // cmd[2:0]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tx_line[0], tx_busy[1], rx_data[9:2], rx_data_valid[10], rx_fill[18:11],
  // parity_error[19], byte_received[20], rx_overflow[21], zero[23:22]
  output logic [23:0]      m_tdata
);

  localparam int RX_AW = sutp_pkg::RX_AW;
  localparam int TX_AW = sutp_pkg::TX_AW;
  localparam int RX_CW = sutp_pkg::RX_CW;
  localparam int TX_CW = sutp_pkg::TX_CW;

  logic [2:0]       parity_mode;
  logic [3:0]       tx_slot, tx_slot_next;
  logic [7:0]       tx_shift, tx_shift_next;
  logic [TX_CW-1:0] tx_sent, tx_sent_next;
  logic [TX_CW-1:0] tx_total, tx_total_next;
  logic             tx_active, tx_active_next;
  logic             tx_parity_acc, tx_parity_acc_next;
  logic             tx_level, tx_level_next;
  logic [3:0]       rx_slot, rx_slot_next;
  logic [7:0]       rx_shift, rx_shift_next;
  logic             rx_armed, rx_armed_next;
  logic             rx_parity_acc, rx_parity_acc_next;
  logic             rx_perr, rx_perr_next;
  logic [RX_AW-1:0] rx_head, rx_head_next;
  logic [RX_AW-1:0] rx_tail, rx_tail_next;
  logic [RX_CW-1:0] rx_count, rx_count_next;

  logic             accept;
  logic             rx_line;
  logic [7:0]       tx_byte;
  logic [6:0]       tx_index;
  logic [7:0]       tx_length;

  logic             tx_we;
  logic [7:0]       tx_rdata;
  logic             rx_we;
  logic [7:0]       rx_rdata;

  sutp_pkg::res_t   res;
  sutp_pkg::res_t   out_main, out_skid;
  logic             main_valid, skid_valid;

  assign accept    = s_tvalid & s_tready;
  assign rx_line   = s_tdata[0];
  assign tx_byte   = s_tdata[8:1];
  assign tx_index  = s_tdata[15:9];
  assign tx_length = s_tdata[23:16];

  sutp_ram #(
    .WIDTH (8),
    .DEPTH (sutp_pkg::TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (TX_AW'(tx_index)),
    .wdata (tx_byte),
    .raddr (tx_sent_next[TX_AW-1:0]),
    .rdata (tx_rdata)
  );

  sutp_ram #(
    .WIDTH (8),
    .DEPTH (sutp_pkg::RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_tail),
    .wdata (rx_shift),
    .raddr (rx_head_next),
    .rdata (rx_rdata)
  );

  always_comb begin
    logic got;
    logic ovf;
    logic finish;
    logic [TX_CW:0] sent_inc;
    got                = 1'b0;
    ovf                = 1'b0;
    finish             = 1'b0;
    sent_inc           = {1'b0, tx_sent} + 1'b1;
    tx_slot_next       = tx_slot;
    tx_shift_next      = tx_shift;
    tx_sent_next       = tx_sent;
    tx_total_next      = tx_total;
    tx_active_next     = tx_active;
    tx_parity_acc_next = tx_parity_acc;
    tx_level_next      = tx_level;
    rx_slot_next       = rx_slot;
    rx_shift_next      = rx_shift;
    rx_armed_next      = rx_armed;
    rx_parity_acc_next = rx_parity_acc;
    rx_perr_next       = rx_perr;
    rx_head_next       = rx_head;
    rx_tail_next       = rx_tail;
    rx_count_next      = rx_count;
    tx_we              = 1'b0;
    rx_we              = 1'b0;
    res                = '0;

    if (accept) begin
      case (sutp_pkg::cmd_t'(s_tuser))
        sutp_pkg::CMD_TICK: begin
          if (tx_active) begin
            if (tx_slot == sutp_pkg::SLOT_START) begin
              tx_shift_next      = (32'(tx_sent) < sutp_pkg::TX_DEPTH) ? tx_rdata : 8'd0;
              tx_level_next      = 1'b0;
              tx_parity_acc_next = 1'b0;
              tx_slot_next       = 4'd1;
            end else if (tx_slot <= sutp_pkg::SLOT_LAST_D) begin
              tx_level_next      = tx_shift[0];
              tx_parity_acc_next = tx_parity_acc ^ tx_shift[0];
              tx_shift_next      = {1'b0, tx_shift[7:1]};
              tx_slot_next       = tx_slot + 4'd1;
            end else if (tx_slot == sutp_pkg::SLOT_PARITY) begin
              case (sutp_pkg::par_t'(parity_mode))
                sutp_pkg::PAR_SPACE: tx_level_next = 1'b0;
                sutp_pkg::PAR_EVEN:  tx_level_next = tx_parity_acc;
                sutp_pkg::PAR_ODD:   tx_level_next = ~tx_parity_acc;
                default:             tx_level_next = 1'b1;
              endcase
              tx_slot_next = sutp_pkg::SLOT_STOP;
            end else begin
              tx_level_next = 1'b1;
              tx_sent_next  = sent_inc[TX_CW-1:0];
              if (sent_inc >= {1'b0, tx_total}) begin
                tx_active_next = 1'b0;
                tx_total_next  = '0;
                tx_sent_next   = '0;
              end
              tx_slot_next = sutp_pkg::SLOT_START;
            end
          end else if (rx_armed) begin
            if (rx_slot == sutp_pkg::SLOT_START) begin
              rx_perr_next = 1'b0;
              if (!rx_line) begin
                rx_slot_next       = 4'd1;
                rx_shift_next      = 8'd0;
                rx_parity_acc_next = 1'b0;
              end
            end else if (rx_slot <= sutp_pkg::SLOT_LAST_D) begin
              rx_shift_next      = {rx_line, rx_shift[7:1]};
              rx_parity_acc_next = rx_parity_acc ^ rx_line;
              rx_slot_next       = rx_slot + 4'd1;
            end else if (rx_slot == sutp_pkg::SLOT_PARITY) begin
              rx_slot_next = sutp_pkg::SLOT_STOP;
              case (sutp_pkg::par_t'(parity_mode))
                sutp_pkg::PAR_MARK:  if (!rx_line) rx_perr_next = 1'b1;
                sutp_pkg::PAR_SPACE: if (rx_line) rx_perr_next = 1'b1;
                sutp_pkg::PAR_EVEN:  if (rx_line != rx_parity_acc) rx_perr_next = 1'b1;
                sutp_pkg::PAR_ODD:   if (rx_line == rx_parity_acc) rx_perr_next = 1'b1;
                default:             finish = 1'b1;
              endcase
            end else begin
              finish = 1'b1;
            end
            if (finish) begin
              if (rx_line) begin
                if (32'(rx_count) >= sutp_pkg::RX_DEPTH) begin
                  ovf = 1'b1;
                end else begin
                  rx_we         = 1'b1;
                  rx_tail_next  = (rx_tail == RX_AW'(sutp_pkg::RX_DEPTH - 1)) ?
                                  '0 : rx_tail + 1'b1;
                  rx_count_next = rx_count + 1'b1;
                  got           = 1'b1;
                end
              end
              rx_armed_next = 1'b0;
              rx_slot_next  = sutp_pkg::SLOT_START;
            end
          end
        end
        sutp_pkg::CMD_WRITE: begin
          tx_we = (32'(tx_index) < sutp_pkg::TX_DEPTH);
        end
        sutp_pkg::CMD_SEND: begin
          if (tx_length != 8'd0) begin
            tx_total_next  = (32'(tx_length) > sutp_pkg::TX_DEPTH) ?
                             TX_CW'(sutp_pkg::TX_DEPTH) : TX_CW'(tx_length);
            tx_sent_next   = '0;
            tx_slot_next   = sutp_pkg::SLOT_START;
            tx_active_next = 1'b1;
            tx_level_next  = 1'b1;
          end
        end
        sutp_pkg::CMD_ARM: begin
          rx_armed_next      = 1'b1;
          rx_slot_next       = sutp_pkg::SLOT_START;
          rx_parity_acc_next = 1'b0;
        end
        sutp_pkg::CMD_POP: begin
          if (rx_count != '0) begin
            res.rx_data       = rx_rdata;
            res.rx_data_valid = 1'b1;
            rx_head_next      = (rx_head == RX_AW'(sutp_pkg::RX_DEPTH - 1)) ?
                                '0 : rx_head + 1'b1;
            rx_count_next     = rx_count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    res.tx_line       = tx_level_next;
    res.tx_busy       = tx_active_next;
    res.rx_fill       = 8'(rx_count_next);
    res.parity_error  = rx_perr_next;
    res.byte_received = got;
    res.rx_overflow   = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_mode   <= sutp_pkg::PARITY_RESET;
      tx_slot       <= sutp_pkg::SLOT_START;
      tx_shift      <= 8'd0;
      tx_sent       <= '0;
      tx_total      <= '0;
      tx_active     <= 1'b0;
      tx_parity_acc <= 1'b0;
      tx_level      <= 1'b1;
      rx_slot       <= sutp_pkg::SLOT_START;
      rx_shift      <= 8'd0;
      rx_armed      <= 1'b0;
      rx_parity_acc <= 1'b0;
      rx_perr       <= 1'b0;
      rx_head       <= '0;
      rx_tail       <= '0;
      rx_count      <= '0;
    end else begin
      if (cfg_we) begin
        parity_mode <= cfg_wdata;
      end
      tx_slot       <= tx_slot_next;
      tx_shift      <= tx_shift_next;
      tx_sent       <= tx_sent_next;
      tx_total      <= tx_total_next;
      tx_active     <= tx_active_next;
      tx_parity_acc <= tx_parity_acc_next;
      tx_level      <= tx_level_next;
      rx_slot       <= rx_slot_next;
      rx_shift      <= rx_shift_next;
      rx_armed      <= rx_armed_next;
      rx_parity_acc <= rx_parity_acc_next;
      rx_perr       <= rx_perr_next;
      rx_head       <= rx_head_next;
      rx_tail       <= rx_tail_next;
      rx_count      <= rx_count_next;
    end
  end

  assign s_tready = ~skid_valid;
  assign m_tvalid = main_valid;
  assign m_tdata  = out_main;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_valid && m_tready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= accept;
      end
    end else if (accept) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_valid && m_tready) begin
      out_main <= skid_valid ? out_skid : res;
    end else if (accept) begin
      if (!main_valid) begin
        out_main <= res;
      end else begin
        out_skid <= res;
      end
    end
  end

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    32'(rx_count) <= sutp_pkg::RX_DEPTH)
    else $error("Receive ring count exceeds its depth.");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("Skid register holds a result while the output register is empty.");

  a_tx_run: assert property (@(posedge clk) disable iff (rst)
    tx_active |-> (tx_total != '0) && (tx_sent < tx_total))
    else $error("Active send run has an inconsistent byte count.");

  a_rx_one_outcome: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(res.byte_received && res.rx_overflow))
    else $error("A frame was both stored and dropped.");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("No result is offered after a transfer was taken.");

endmodule

`default_nettype wire
